// ===== rtl/edit_distance_engine_defines.svh =====
// assertion macros shared by the edit distance engine
`ifndef EDIT_DISTANCE_ENGINE_DEFINES_SVH
`define EDIT_DISTANCE_ENGINE_DEFINES_SVH

`ifndef ASSERT_OFF

// same-cycle implication, checked at every rising edge out of reset
`define EDE_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("edit distance engine check failed");

// next-cycle implication, checked at every rising edge out of reset
`define EDE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("edit distance engine check failed");

`else

`define EDE_ASSERT_NOW(lbl, clk, rst_n, ante, cons)
`define EDE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

// ===== rtl/ede_pkg.sv =====
// types and constants shared by the edit distance engine modules
`timescale 1ns / 1ps

package ede_pkg;

    localparam int KIND_W   = 2;
    localparam int SYM_W    = 8;
    localparam int DIST_W   = 7;
    localparam logic [DIST_W-1:0] DIST_MAX = 7'd127;

    // input item kinds; the spare code is ignored
    typedef enum logic [KIND_W-1:0] {
        KIND_APPEND_FIRST  = 2'd0,
        KIND_APPEND_SECOND = 2'd1,
        KIND_COMPUTE       = 2'd2
    } t_kind;

    // commands from the controller to the datapath
    typedef enum logic [2:0] {
        OP_NONE   = 3'd0,
        OP_APP_A  = 3'd1,
        OP_APP_B  = 3'd2,
        OP_START  = 3'd3,
        OP_INIT   = 3'd4,
        OP_ROW    = 3'd5,
        OP_CELL   = 3'd6,
        OP_FINISH = 3'd7
    } t_dp_op;

    // status from the datapath to the controller
    typedef struct packed {
        logic j_last;
        logic i_last;
        logic n_zero;
        logic m_zero;
        logic out_free;
    } t_dp_status;

endpackage

// ===== rtl/ede_ram.sv =====
// generic simple dual-port ram with registered read
`timescale 1ns / 1ps

module ede_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 64,
    parameter int ADDR_W = 6
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/ede_ctrl.sv =====
// controller state machine of the edit distance engine
`timescale 1ns / 1ps

module ede_ctrl (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    input  logic [ede_pkg::KIND_W-1:0]    i_kind,
    input  ede_pkg::t_dp_status           i_status,
    output logic                          o_in_stall,
    output ede_pkg::t_dp_op               o_op
);
    import ede_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_INIT = 5'b00010,
        S_ROW  = 5'b00100,
        S_CELL = 5'b01000,
        S_DONE = 5'b10000
    } t_state;

    t_state r_state;
    t_state n_state;
    t_dp_op w_op;

    // next state and datapath command
    always_comb begin
        n_state = r_state;
        w_op    = OP_NONE;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    case (i_kind)
                        KIND_APPEND_FIRST:  w_op = OP_APP_A;
                        KIND_APPEND_SECOND: w_op = OP_APP_B;
                        KIND_COMPUTE: begin
                            w_op    = OP_START;
                            n_state = S_INIT;
                        end
                        default: w_op = OP_NONE;
                    endcase
                end
            end
            S_INIT: begin
                w_op = OP_INIT;
                if (i_status.j_last) begin
                    n_state = i_status.n_zero ? S_DONE : S_ROW;
                end
            end
            S_ROW: begin
                w_op = OP_ROW;
                if (!i_status.m_zero) begin
                    n_state = S_CELL;
                end else if (i_status.i_last) begin
                    n_state = S_DONE;
                end
            end
            S_CELL: begin
                w_op = OP_CELL;
                if (i_status.j_last) begin
                    n_state = i_status.i_last ? S_DONE : S_ROW;
                end
            end
            S_DONE: begin
                if (i_status.out_free) begin
                    w_op    = OP_FINISH;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_stall = (r_state != S_IDLE);
    assign o_op       = w_op;

endmodule

// ===== rtl/ede_dp.sv =====
// datapath of the edit distance engine: string stores, row buffer, cell update
`timescale 1ns / 1ps

module ede_dp #(
    parameter int MAX_LEN = 64
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  ede_pkg::t_dp_op               i_op,
    input  logic [ede_pkg::SYM_W-1:0]     i_symbol,
    input  logic                          i_out_stall,
    output ede_pkg::t_dp_status           o_status,
    output logic                          o_out_valid,
    output logic [ede_pkg::DIST_W-1:0]    o_distance,
    output logic                          o_truncated
);
    import ede_pkg::*;

    localparam int LW  = $clog2(MAX_LEN + 1);
    localparam int SAW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
    localparam int OW  = (LW > DIST_W) ? LW : DIST_W;

    // lengths, flag and output register
    logic [LW-1:0]     r_n, n_n;
    logic [LW-1:0]     r_m, n_m;
    logic              r_ovf, n_ovf;
    logic              r_out_valid, n_out_valid;
    logic [DIST_W-1:0] r_distance;
    logic              r_truncated;

    // row walk registers
    logic [LW-1:0]     r_i, n_i;
    logic [LW-1:0]     r_j, n_j;
    logic [LW-1:0]     r_left, n_left;
    logic [LW-1:0]     r_diag, n_diag;

    // memory ports
    logic              w_a_we, w_b_we, w_row_we;
    logic [SAW-1:0]    w_a_raddr, w_b_raddr;
    logic [LW-1:0]     w_row_waddr, w_row_wdata, w_row_raddr;
    logic [SYM_W-1:0]  w_a_rdata, w_b_rdata;
    logic [LW-1:0]     w_up;

    logic              w_full_a, w_full_b;
    logic [LW-1:0]     w_i_m1, w_j_p1;
    logic [LW-1:0]     w_min1, w_min2, w_cell;
    logic [OW-1:0]     w_left_ext;
    logic [DIST_W-1:0] w_dist;
    logic              w_out_free;

    assign w_full_a = (r_n == LW'(MAX_LEN));
    assign w_full_b = (r_m == LW'(MAX_LEN));
    assign w_i_m1   = r_i - LW'(1);
    assign w_j_p1   = r_j + LW'(1);

    // cell update: copy diagonal on match, else one plus the smallest neighbor
    assign w_min1 = (r_left < w_up) ? r_left : w_up;
    assign w_min2 = (w_min1 < r_diag) ? w_min1 : r_diag;
    assign w_cell = (w_a_rdata == w_b_rdata) ? r_diag : (w_min2 + LW'(1));

    // distance saturates to the field width
    assign w_left_ext = OW'(r_left);
    assign w_dist     = (w_left_ext > OW'(DIST_MAX)) ? DIST_MAX : w_left_ext[DIST_W-1:0];

    assign w_out_free = !r_out_valid || !i_out_stall;

    // string store writes
    assign w_a_we    = (i_op == OP_APP_A) && !w_full_a;
    assign w_b_we    = (i_op == OP_APP_B) && !w_full_b;
    assign w_a_raddr = w_i_m1[SAW-1:0];
    assign w_b_raddr = (i_op == OP_CELL) ? r_j[SAW-1:0] : '0;

    // row buffer ports
    assign w_row_we    = (i_op == OP_INIT) || (i_op == OP_ROW) || (i_op == OP_CELL);
    assign w_row_waddr = (i_op == OP_ROW) ? '0 : r_j;
    assign w_row_raddr = (i_op == OP_CELL) ? w_j_p1 : LW'(1);

    always_comb begin
        case (i_op)
            OP_INIT: w_row_wdata = r_j;
            OP_ROW:  w_row_wdata = r_i;
            default: w_row_wdata = w_cell;
        endcase
    end

    // next values
    always_comb begin
        n_n         = r_n;
        n_m         = r_m;
        n_ovf       = r_ovf;
        n_i         = r_i;
        n_j         = r_j;
        n_left      = r_left;
        n_diag      = r_diag;
        n_out_valid = r_out_valid && i_out_stall;
        case (i_op)
            OP_APP_A: begin
                if (w_full_a) begin
                    n_ovf = 1'b1;
                end else begin
                    n_n = r_n + LW'(1);
                end
            end
            OP_APP_B: begin
                if (w_full_b) begin
                    n_ovf = 1'b1;
                end else begin
                    n_m = r_m + LW'(1);
                end
            end
            OP_START: begin
                n_i = LW'(1);
                n_j = '0;
            end
            OP_INIT: begin
                n_left = r_j;
                n_j    = w_j_p1;
            end
            OP_ROW: begin
                n_left = r_i;
                n_diag = w_i_m1;
                n_j    = LW'(1);
                if (r_m == '0) begin
                    n_i = r_i + LW'(1);
                end
            end
            OP_CELL: begin
                n_left = w_cell;
                n_diag = w_up;
                n_j    = w_j_p1;
                if (r_j == r_m) begin
                    n_i = r_i + LW'(1);
                end
            end
            OP_FINISH: begin
                n_out_valid = 1'b1;
                n_n         = '0;
                n_m         = '0;
                n_ovf       = 1'b0;
            end
            default: n_n = r_n;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_n         <= '0;
            r_m         <= '0;
            r_ovf       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_n         <= n_n;
            r_m         <= n_m;
            r_ovf       <= n_ovf;
            r_out_valid <= n_out_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_i    <= n_i;
        r_j    <= n_j;
        r_left <= n_left;
        r_diag <= n_diag;
        if (i_op == OP_FINISH) begin
            r_distance  <= w_dist;
            r_truncated <= r_ovf;
        end
    end

    // first string store
    ede_ram #(
        .WIDTH  (SYM_W),
        .DEPTH  (MAX_LEN),
        .ADDR_W (SAW)
    ) u_first_ram (
        .i_clk   (i_clk),
        .i_we    (w_a_we),
        .i_waddr (r_n[SAW-1:0]),
        .i_wdata (i_symbol),
        .i_raddr (w_a_raddr),
        .o_rdata (w_a_rdata)
    );

    // second string store
    ede_ram #(
        .WIDTH  (SYM_W),
        .DEPTH  (MAX_LEN),
        .ADDR_W (SAW)
    ) u_second_ram (
        .i_clk   (i_clk),
        .i_we    (w_b_we),
        .i_waddr (r_m[SAW-1:0]),
        .i_wdata (i_symbol),
        .i_raddr (w_b_raddr),
        .o_rdata (w_b_rdata)
    );

    // dynamic-programming row buffer
    ede_ram #(
        .WIDTH  (LW),
        .DEPTH  (MAX_LEN + 1),
        .ADDR_W (LW)
    ) u_row_ram (
        .i_clk   (i_clk),
        .i_we    (w_row_we),
        .i_waddr (w_row_waddr),
        .i_wdata (w_row_wdata),
        .i_raddr (w_row_raddr),
        .o_rdata (w_up)
    );

    assign o_status.j_last   = (r_j == r_m);
    assign o_status.i_last   = (r_i == r_n);
    assign o_status.n_zero   = (r_n == '0);
    assign o_status.m_zero   = (r_m == '0);
    assign o_status.out_free = w_out_free;

    assign o_out_valid = r_out_valid;
    assign o_distance  = r_distance;
    assign o_truncated = r_truncated;

endmodule

// ===== rtl/edit_distance_engine.sv =====
// top level of the edit distance engine
// Levenshtein edit distance engine. Items of kind 0 and 1 append a byte to the first or
// second string (up to MAX_LEN each; later appends are dropped and flagged). An item of
// kind 2 computes the distance, delivers it with the dropped-append flag as one result
// transfer, and clears both strings; kind 3 is ignored. A compute fills the table of
// (n + 1) * (m + 1) cells for lengths n and m, one cell per cycle, set by the one read
// and one write port of the row buffer memory; the input is stalled until the compute ends.
// A finished result sits in an output register, so appends are taken while it waits, and a
// following compute holds in its last step until the previous result has been taken.
`timescale 1ns / 1ps
`include "edit_distance_engine_defines.svh"

module edit_distance_engine #(
    parameter int MAX_LEN = 64
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [ede_pkg::KIND_W-1:0]    i_kind,
    input  logic [ede_pkg::SYM_W-1:0]     i_symbol,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [ede_pkg::DIST_W-1:0]    o_distance,
    output logic                          o_truncated
);
    import ede_pkg::*;

    t_dp_op     w_op;
    t_dp_status w_status;

    // sequencer
    ede_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_kind     (i_kind),
        .i_status   (w_status),
        .o_in_stall (o_in_stall),
        .o_op       (w_op)
    );

    // storage and cell arithmetic
    ede_dp #(
        .MAX_LEN (MAX_LEN)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_op        (w_op),
        .i_symbol    (i_symbol),
        .i_out_stall (i_out_stall),
        .o_status    (w_status),
        .o_out_valid (o_out_valid),
        .o_distance  (o_distance),
        .o_truncated (o_truncated)
    );

    // a result is never loaded over one that is still waiting
    `EDE_ASSERT_NOW(a_no_overwrite, i_clk, i_rst_n, w_op == OP_FINISH, !(o_out_valid && i_out_stall))

    // finishing a compute always presents a result next cycle
    `EDE_ASSERT_NEXT(a_finish_shows, i_clk, i_rst_n, w_op == OP_FINISH, o_out_valid)

    // a result appears only after a finish command
    `EDE_ASSERT_NOW(a_valid_source, i_clk, i_rst_n, $rose(o_out_valid), $past(w_op == OP_FINISH))

    // the input is held off while the table is being walked
    `EDE_ASSERT_NOW(a_busy_stalls, i_clk, i_rst_n, w_op == OP_CELL || w_op == OP_ROW, o_in_stall)

endmodule
